// File: design/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds command codes, status codes, cell operations and default sizes.
// Used by deq_cell, double_ended_queue and deq_checker.
package deq_pkg;

    localparam int DefaultDepth     = 16;
    localparam int DefaultDataWidth = 32;

    // Widths of the stream fields
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int IN_W     = 40;   // cmd + value, padded to whole bytes
    localparam int OUT_W    = 104;  // data, status, front, back, count, is_empty

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // Operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

// File: design/deq_cell.sv
// One storage cell of the deque row: an entry and its valid bit.
// Shifts toward either neighbor or loads the pushed word; uses deq_pkg.
module deq_cell #(
    parameter int DATA_WIDTH = deq_pkg::DefaultDataWidth
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  deq_pkg::cell_ctrl_t   ctrl,
    input  logic [DATA_WIDTH-1:0] din,
    input  logic [DATA_WIDTH-1:0] prev_data,
    input  logic                  prev_valid,
    input  logic [DATA_WIDTH-1:0] next_data,
    input  logic                  next_valid,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  valid
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  valid_reg;
    logic                  valid_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            OP_PUSH_BACK:
            begin
                // first free cell takes the word
                if (!valid_reg && prev_valid)
                begin
                    data_next  = din;
                    valid_next = 1'b1;
                end
            end
            OP_PUSH_FRONT:
            begin
                data_next  = prev_data;
                valid_next = prev_valid;
            end
            OP_POP_FRONT:
            begin
                data_next  = next_data;
                valid_next = next_valid;
            end
            OP_POP_BACK:
            begin
                // only the last held cell drops out
                valid_next = valid_reg & next_valid;
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// File: design/double_ended_queue.sv
// Double-ended queue: an accepted command goes to S_RESULT, which registers its
// result word; no new command is taken until then. The row of cells shifts in the
// accept cycle, the front/back/count summary is registered in the next.
// Entries are packed from cell 0 (front); the back is the last valid cell.
// Reset (rst_n low, asynchronous) empties the queue; entry data is not cleared.
// Depends on deq_pkg and deq_cell.
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DefaultDepth,
    parameter int DATA_WIDTH = deq_pkg::DefaultDataWidth
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [deq_pkg::IN_W-1:0]  s_tdata,  // cmd[2:0], value[34:3], zero pad
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [deq_pkg::OUT_W-1:0] m_tdata   // data[31:0], status[33:32],
                                                 // front_value[65:34],
                                                 // back_value[97:66],
                                                 // count[102:98], is_empty[103]
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_RESULT
    } state_t;

    state_t                state_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [DATA_WIDTH-1:0] popped_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic [CMD_W-1:0]      cmd_in;
    logic [DATA_WIDTH-1:0] value_in;
    logic                  accept;
    logic                  full;
    logic                  empty;
    cell_ctrl_t            ctrl;
    logic [STATUS_W-1:0]   status_next;
    logic [DATA_WIDTH-1:0] popped_next;
    logic [CNT_W-1:0]      count_next;

    logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
    logic                  cell_valid [DEPTH];
    logic [DATA_WIDTH-1:0] back_term  [DEPTH];
    logic [DATA_WIDTH-1:0] back_sel;

    assign cmd_in   = s_tdata[CMD_W-1:0];
    assign value_in = DATA_WIDTH'(s_tdata[CMD_W +: VALUE_W]);
    assign accept   = s_tvalid && s_tready;
    assign full     = cell_valid[DEPTH-1];
    assign empty    = !cell_valid[0];

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Command decode; the cells act only in the accept cycle
    always_comb
    begin
        ctrl.op     = OP_NONE;
        status_next = STAT_OK;
        popped_next = '0;
        count_next  = count_reg;
        unique case (cmd_in) inside
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ctrl.op    = (cmd_in == CMD_PUSH_BACK) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    ctrl.op     = (cmd_in == CMD_POP_FRONT) ? OP_POP_FRONT : OP_POP_BACK;
                    popped_next = (cmd_in == CMD_POP_FRONT) ? cell_data[0] : back_sel;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            CMD_CLEAR:
            begin
                ctrl.op    = OP_CLEAR;
                count_next = '0;
            end
            default:
            begin
                ctrl.op = OP_NONE;
            end
        endcase
        if (!accept)
        begin
            ctrl.op = OP_NONE;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] prev_d;
            logic                  prev_v;
            logic [DATA_WIDTH-1:0] next_d;
            logic                  next_v;

            if (gi == 0)
            begin : g_first
                assign prev_d = value_in;
                assign prev_v = 1'b1;
            end
            else
            begin : g_mid_prev
                assign prev_d = cell_data[gi-1];
                assign prev_v = cell_valid[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign next_d = cell_data[gi];
                assign next_v = 1'b0;
            end
            else
            begin : g_mid_next
                assign next_d = cell_data[gi+1];
                assign next_v = cell_valid[gi+1];
            end

            deq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .din        (value_in),
                .prev_data  (prev_d),
                .prev_valid (prev_v),
                .next_data  (next_d),
                .next_valid (next_v),
                .data       (cell_data[gi]),
                .valid      (cell_valid[gi])
            );

            // only the last held cell contributes to the back value
            assign back_term[gi] = (cell_valid[gi] && !next_v) ? cell_data[gi] : '0;
        end
    endgenerate

    always_comb
    begin
        back_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_sel = back_sel | back_term[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            count_reg     <= '0;
            popped_reg    <= '0;
            status_reg    <= STAT_OK;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        count_reg  <= count_next;
                        popped_reg <= popped_next;
                        status_reg <= status_next;
                        state_reg  <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    // cells have settled and the output slot is free
                    out_data_reg  <= {
                        empty,
                        COUNT_W'(count_reg),
                        empty ? VALUE_W'(0) : VALUE_W'(back_sel),
                        empty ? VALUE_W'(0) : VALUE_W'(cell_data[0]),
                        status_reg,
                        VALUE_W'(popped_reg)
                    };
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/deq_checker.sv
// Port-level checks on the deque result stream, bound to the top level.
// Depends on deq_pkg and double_ended_queue.
module deq_port_checks (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [deq_pkg::OUT_W-1:0] m_tdata
);
    import deq_pkg::*;

    logic [VALUE_W-1:0]  c_data;
    logic [STATUS_W-1:0] c_status;
    logic [VALUE_W-1:0]  c_front;
    logic [VALUE_W-1:0]  c_back;
    logic [COUNT_W-1:0]  c_count;
    logic                c_empty;

    assign c_data   = m_tdata[31:0];
    assign c_status = m_tdata[33:32];
    assign c_front  = m_tdata[65:34];
    assign c_back   = m_tdata[97:66];
    assign c_count  = m_tdata[102:98];
    assign c_empty  = m_tdata[103];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> c_empty == (c_count == '0))
        else $error("is_empty disagrees with count");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && c_empty |-> c_front == '0 && c_back == '0)
        else $error("front or back nonzero on empty queue");

    a_err_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (c_status == STAT_EMPTY || c_status == STAT_FULL) |-> c_data == '0)
        else $error("data nonzero on error status");

    a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && c_status == STAT_EMPTY |-> c_empty)
        else $error("empty error while queue holds entries");

endmodule

bind double_ended_queue deq_port_checks u_deq_port_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/deq_checker.sv
// Checker for double_ended_queue: follows both stream channels, keeps its own
// ring copy of the queue to predict each result word, and compares on arrival.
// Depends on deq_pkg.
module deq_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [deq_pkg::IN_W-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [deq_pkg::OUT_W-1:0] m_tdata,
    output int                        fail_count,
    output int                        pending
);
    import deq_pkg::*;

    localparam int Depth = DefaultDepth;

    // m_tdata field offsets, lowest field first
    localparam int StatusLo = VALUE_W;
    localparam int FrontLo  = StatusLo + STATUS_W;
    localparam int BackLo   = FrontLo + VALUE_W;
    localparam int CountLo  = BackLo + VALUE_W;
    localparam int EmptyLo  = CountLo + COUNT_W;

    typedef struct packed {
        logic [VALUE_W-1:0]  data;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  front_value;
        logic [VALUE_W-1:0]  back_value;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
    } deq_result_t;

    logic [VALUE_W-1:0] ring [Depth];
    int unsigned        head_idx;
    int unsigned        fill;
    deq_result_t        result_fifo [$];

    function automatic int unsigned back_idx();
        return (head_idx + fill + Depth - 1) % Depth;
    endfunction

    // Applies one command to the ring copy and returns the word it must produce
    function automatic deq_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [VALUE_W-1:0] val);
        deq_result_t r;
        r = '0;
        r.status = STAT_OK;
        case (cmd)
            CMD_PUSH_BACK:
                if (fill >= Depth)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    ring[(head_idx + fill) % Depth] = val;
                    fill++;
                end
            CMD_PUSH_FRONT:
                if (fill >= Depth)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    head_idx = (head_idx + Depth - 1) % Depth;
                    ring[head_idx] = val;
                    fill++;
                end
            CMD_POP_FRONT:
                if (fill == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    r.data = ring[head_idx];
                    head_idx = (head_idx + 1) % Depth;
                    fill--;
                end
            CMD_POP_BACK:
                if (fill == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    r.data = ring[back_idx()];
                    fill--;
                end
            CMD_CLEAR:
            begin
                head_idx = 0;
                fill = 0;
            end
            default: ;  // unused codes leave the queue alone
        endcase
        if (fill != 0)
        begin
            r.front_value = ring[head_idx];
            r.back_value  = ring[back_idx()];
        end
        r.count    = COUNT_W'(fill);
        r.is_empty = (fill == 0);
        return r;
    endfunction

    task automatic flag_error(input string what, input deq_result_t want,
                              input deq_result_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t ERROR %s: exp data=%h st=%0d front=%h back=%h cnt=%0d empty=%0b",
                     $realtime, what, want.data, want.status, want.front_value,
                     want.back_value, want.count, want.is_empty);
            $display("%0t        act data=%h st=%0d front=%h back=%h cnt=%0d empty=%0b",
                     $realtime, got.data, got.status, got.front_value,
                     got.back_value, got.count, got.is_empty);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deq_result_t got;
        deq_result_t want;
        if (!rst_n)
        begin
            head_idx = 0;
            fill = 0;
            result_fifo.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // result side first so a same-edge command cannot mask a stray word
            if (m_tvalid && m_tready)
            begin
                got.data        = m_tdata[VALUE_W-1:0];
                got.status      = m_tdata[StatusLo +: STATUS_W];
                got.front_value = m_tdata[FrontLo +: VALUE_W];
                got.back_value  = m_tdata[BackLo +: VALUE_W];
                got.count       = m_tdata[CountLo +: COUNT_W];
                got.is_empty    = m_tdata[EmptyLo];
                if (result_fifo.size() == 0)
                begin
                    flag_error("unexpected word", '0, got);
                end
                else
                begin
                    want = result_fifo.pop_front();
                    if (got.data !== want.data || got.status !== want.status ||
                        got.front_value !== want.front_value ||
                        got.back_value !== want.back_value ||
                        got.count !== want.count || got.is_empty !== want.is_empty)
                        flag_error("mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready)
                result_fifo.push_back(apply_command(s_tdata[CMD_W-1:0],
                                                    s_tdata[CMD_W +: VALUE_W]));
            pending = result_fifo.size();
        end
    end

endmodule

// File: dv/tb_double_ended_queue.sv
// Testbench top for double_ended_queue: clock, reset, command stimulus,
// result-side backpressure, stall watchdog and verdict.
// Depends on deq_pkg, double_ended_queue and deq_checker.
module tb_double_ended_queue;
    import deq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_CLEAR + 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
    localparam int               RandomItems   = 600;
    localparam int               StallLimit    = 4000;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    int               fail_count;
    int               pending;
    int               stall_cycles;
    logic             steady;   // no idling on either side while set

    double_ended_queue i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    deq_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(negedge clk)
        m_tready <= steady || ($urandom_range(99) >= 24);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
        while (!steady && $urandom_range(99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - CMD_W - VALUE_W){1'b0}}, val, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return VALUE_W'(1) << $urandom_range(VALUE_W - 1);
            default: return $urandom();
        endcase
    endfunction

    // push_pct sets how hard a segment drives toward full or empty
    function automatic logic [CMD_W-1:0] pick_cmd(input int push_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 2)
            return CMD_CLEAR;
        if (r < 4)
            return CMD_UNUSED_LO + CMD_W'($urandom_range(CMD_UNUSED_HI - CMD_UNUSED_LO));
        if (r < 4 + push_pct * 96 / 100)
            return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
    endfunction

    initial
    begin
        int push_pct;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        steady       = 1'b0;
        push_pct     = 50;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // empty-queue errors and unused codes
        send_word(CMD_POP_FRONT, '1);
        send_word(CMD_POP_BACK, '1);
        send_word(CMD_UNUSED_LO, '1);
        send_word(CMD_UNUSED_HI, '0);
        // extremes at both ends, then fill to the brim
        send_word(CMD_PUSH_BACK, '1);
        send_word(CMD_PUSH_FRONT, '0);
        for (int k = 0; k < DefaultDepth - 2; k++)
            send_word(k[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
        send_word(CMD_PUSH_BACK, pick_value());
        send_word(CMD_PUSH_FRONT, pick_value());
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_CLEAR, '1);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_UNUSED_LO + 3'd1, pick_value());

        for (int i = 0; i < RandomItems; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(4))
                    0: push_pct = 90;
                    1: push_pct = 10;
                    2: push_pct = 60;
                    3: push_pct = 40;
                    default: push_pct = 50;
                endcase
            end
            steady = (i >= 250 && i < 400);
            send_word(pick_cmd(push_pct), pick_value());
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
